// ===== design/ede_pkg.sv =====
// Shared types and constants for the edit distance engine.
package ede_pkg;

	localparam int MAX_LEN = 64;
	localparam int LW      = $clog2(MAX_LEN + 1);
	localparam int SYM_W   = 8;
	localparam int DIST_W  = 7;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_FEED   = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [SYM_W-1:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} out_word_t;

	// Word handed from one cell to the next. For a row update, left is the
	// new value of the left neighbor and diag its old value. For the finish
	// token, left carries the distance picked up so far.
	typedef struct packed {
		logic             wave;
		logic             fin;
		logic [SYM_W-1:0] sym;
		logic [LW-1:0]    left;
		logic [LW-1:0]    diag;
		logic             ovf;
	} link_t;

	typedef struct packed {
		logic [MAX_LEN-1:0] en;
		logic [SYM_W-1:0]   sym;
	} wr_t;

endpackage

// ===== design/ede_cell.sv =====
// One cell of the DP row: holds one byte of the first word and one row entry.
module ede_cell import ede_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [LW-1:0] idx,
	input  logic          wr_en,
	input  logic [SYM_W-1:0] wr_sym,
	input  link_t         link_in,
	output link_t         link_out
);

	logic [SYM_W-1:0] byte_q;
	logic             used_q;
	logic             fresh_q;
	logic [LW-1:0]    d_q;
	link_t            link_q;

	logic [LW-1:0] d_eff;
	logic [LW-1:0] mn;
	logic [LW-1:0] d_new;

	// A fresh entry reads as its own index, the value after reset.
	assign d_eff = fresh_q ? idx : d_q;

	always_comb begin
		mn = d_eff;
		if (link_in.left < mn) begin
			mn = link_in.left;
		end
		if (link_in.diag < mn) begin
			mn = link_in.diag;
		end
		if (byte_q == link_in.sym) begin
			d_new = link_in.diag;
		end else begin
			d_new = mn + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= 1'b0;
			fresh_q     <= 1'b1;
			link_q.wave <= 1'b0;
			link_q.fin  <= 1'b0;
		end else begin
			link_q.wave <= link_in.wave;
			link_q.fin  <= link_in.fin;
			link_q.sym  <= link_in.sym;
			link_q.ovf  <= link_in.ovf;
			link_q.diag <= d_eff;
			link_q.left <= link_in.left;
			if (wr_en) begin
				used_q <= 1'b1;
			end
			if (link_in.wave) begin
				fresh_q     <= 1'b0;
				link_q.left <= d_new;
			end else if (link_in.fin) begin
				// pick up this entry if it lies inside the first word, then clear
				fresh_q <= 1'b1;
				used_q  <= 1'b0;
				if (used_q) begin
					link_q.left <= d_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byte_q <= wr_sym;
		end
		if (link_in.wave) begin
			d_q <= d_new;
		end
	end

	assign link_out = link_q;

endmodule

// ===== design/ede_ctrl.sv =====
// Command decode, length and count tracking, and injection into the cell row.
module ede_ctrl import ede_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_word_t item,
	input  logic     done,
	output logic     busy,
	output wr_t      wr,
	output link_t    link
);

	logic [LW-1:0] length_q;
	logic [LW-1:0] count_q;
	logic          ovf_q;
	logic          busy_q;
	link_t         link_q;

	logic accept;
	logic append_ok;

	assign accept    = start && !busy_q;
	assign append_ok = accept && (item.cmd == CMD_APPEND) && (count_q == '0)
	                   && (length_q < LW'(MAX_LEN));

	always_comb begin
		wr.sym = item.symbol;
		for (int k = 0; k < MAX_LEN; k++) begin
			wr.en[k] = append_ok && (length_q == LW'(k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			busy_q      <= 1'b0;
			link_q.wave <= 1'b0;
			link_q.fin  <= 1'b0;
		end else begin
			link_q.wave <= 1'b0;
			link_q.fin  <= 1'b0;
			link_q.sym  <= item.symbol;
			link_q.ovf  <= ovf_q;
			link_q.left <= count_q + LW'(1);
			link_q.diag <= count_q;
			if (done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (item.cmd)
					CMD_APPEND: begin
						if (count_q == '0) begin
							if (length_q < LW'(MAX_LEN)) begin
								length_q <= length_q + LW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
					CMD_FEED: begin
						if (count_q < LW'(MAX_LEN)) begin
							link_q.wave <= 1'b1;
							count_q     <= count_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					CMD_FINISH: begin
						// send the token behind the last row update; hold until it exits
						link_q.fin  <= 1'b1;
						link_q.left <= count_q;
						length_q    <= '0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						busy_q      <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign busy = busy_q;
	assign link = link_q;

`ifndef NO_ASSERTIONS
	a_link_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(link_q.wave && link_q.fin))
		else $error("row update and finish token in the same word");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(length_q <= LW'(MAX_LEN)) && (count_q <= LW'(MAX_LEN)))
		else $error("length or count beyond capacity");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		link_q.fin |-> busy_q)
		else $error("finish token injected while not busy");

	a_first_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |=> (length_q == $past(length_q)) || (length_q == '0))
		else $error("first word grew after second word began");
`endif

endmodule

// ===== design/edit_distance_engine.sv =====
// Top level: controller feeding a row of edit distance cells.
// Append and feed commands may follow back to back.
// A finish command holds busy while its token walks the cell row; the result
// strobe rises in the same cycle that busy drops.
// The result is shown for one cycle; the receiver cannot stall it.
// Reset (arst_n low) empties both words, clears overflow and drops any result.
module edit_distance_engine import ede_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  item,
	output logic      busy,
	output logic      result_valid,
	output out_word_t result
);

	link_t     links [0:MAX_LEN];
	wr_t       wr;
	logic      result_valid_q;
	out_word_t result_q;

	ede_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.done   (links[MAX_LEN].fin),
		.busy   (busy),
		.wr     (wr),
		.link   (links[0])
	);

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		ede_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (LW'(k + 1)),
			.wr_en    (wr.en[k]),
			.wr_sym   (wr.sym),
			.link_in  (links[k]),
			.link_out (links[k + 1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= links[MAX_LEN].fin;
		end
	end

	always_ff @(posedge clk) begin
		result_q.distance <= DIST_W'(links[MAX_LEN].left);
		result_q.overflow <= links[MAX_LEN].ovf;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result word while still busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result word repeated");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.cmd == CMD_FINISH)) |=> busy)
		else $error("finish accepted without going busy");
`endif

endmodule
